/* hw/rtl/kadq_pkg.sv */
// ----------------------------------------------------------------------------
// Keyframe-aware drop queue package
// Shared descriptor, transfer payload types and constants of the queue.
// ----------------------------------------------------------------------------
package kadq_pkg;

	localparam int QUEUE_DEPTH_DEF = 8;
	localparam logic [3:0] DEPTH_LIMIT_RST = 4'd8;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef struct packed {
		logic [31:0] id;
		logic        key;
		logic [15:0] handle;
	} desc_t;

	typedef struct packed {
		logic        op;
		logic [31:0] frame_seq;
		logic        is_keyframe;
		logic [15:0] buffer_handle;
	} in_item_t;

	typedef struct packed {
		logic        pop_valid;
		logic [31:0] out_frame_seq;
		logic        out_keyframe;
		logic [15:0] out_handle;
		logic        drop_valid;
		logic        drop_was_key;
		logic [31:0] drop_frame_seq;
		logic [15:0] drop_handle;
		logic [3:0]  occupancy;
	} out_item_t;

endpackage

/* hw/rtl/kadq_desc_ram.sv */
// ----------------------------------------------------------------------------
// Descriptor store
// Single write port and one registered read port holding the queue entries.
// ----------------------------------------------------------------------------
module kadq_desc_ram
	import kadq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	localparam int AW = $clog2(QUEUE_DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  desc_t         wr_data,
	input  logic [AW-1:0] rd_addr,
	output desc_t         rd_data
);

	desc_t mem_q [QUEUE_DEPTH];
	desc_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

/* hw/rtl/keyframe_aware_drop_queue_core.sv */
// ----------------------------------------------------------------------------
// Keyframe-aware drop queue
// Bounded descriptor FIFO; drops the oldest non-keyframe (or head) when full.
// ----------------------------------------------------------------------------
// The input channel carries one operation per transfer: a push of a frame
// descriptor or a pop of the head. The output channel returns exactly one
// result per operation, with the popped or dropped descriptor and the
// occupancy after the operation. The configuration channel is always ready
// and writes the depth limit; the user must write it only while the queue is
// idle, since the block itself does not enforce this. Entries sit in a small
// RAM with the head at address 0. A small sequencer scans the entries one per
// cycle for the oldest non-keyframe (for a pop, the head), then closes the
// gap by moving one entry per cycle through the single RAM read port. Only
// one operation is in flight at a time. A push below the limit appends;
// a pop scans and shifts, and a dropping push scans, shifts and appends; when
// every entry is a keyframe, the scan runs over all of them and drops the
// head. The finished result waits in an output register, so a new operation
// is taken while the receiver stalls; that operation completes once the
// register is free. Reset empties the queue and sets the limit to 8.
// ----------------------------------------------------------------------------
module keyframe_aware_drop_queue_core
	import kadq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [3:0] cfg_data
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int LW = (CW > 4) ? CW : 4;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_SHIFT  = 5'b00100,
		ST_APPEND = 5'b01000,
		ST_RESULT = 5'b10000
	} state_t;

	state_t        state_q;
	in_item_t      item_q;
	logic [CW-1:0] count_q;
	logic [3:0]    limit_q;
	logic [CW-1:0] idx_q;
	logic          chk_vld_s1;
	logic [AW-1:0] chk_idx_s1;
	logic          mv_vld_s1;
	logic [AW-1:0] mv_dst_s1;
	desc_t         head_q;
	out_item_t     res_q;
	out_item_t     out_q;
	logic          out_valid_q;

	desc_t         rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	desc_t         wr_data;

	logic [LW-1:0] lim_raw;
	logic [LW-1:0] lim_eff;
	logic          need_drop;
	logic          is_pop;
	logic          last_chk;
	logic          take_cur;
	logic          hit;
	logic [AW-1:0] hit_pos;
	desc_t         hit_desc;
	logic          out_free;
	out_item_t     res_fin;

	kadq_desc_ram #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(idx_q[AW-1:0]),
		.rd_data(rd_data)
	);

	always_comb begin
		lim_raw = LW'(limit_q);
		if (lim_raw == '0) begin
			lim_eff = LW'(1);
		end else if (lim_raw > LW'(QUEUE_DEPTH)) begin
			lim_eff = LW'(QUEUE_DEPTH);
		end else begin
			lim_eff = lim_raw;
		end
		need_drop = LW'(count_q) >= lim_eff;
	end

	assign is_pop   = (item_q.op == OP_POP);
	assign last_chk = (CW'(chk_idx_s1) == CW'(count_q - CW'(1)));
	assign take_cur = is_pop || !rd_data.key || (chk_idx_s1 == '0);
	assign hit      = chk_vld_s1 && (is_pop || !rd_data.key || last_chk);
	assign hit_pos  = take_cur ? chk_idx_s1 : '0;
	assign hit_desc = take_cur ? rd_data : head_q;

	always_comb begin
		if (state_q == ST_APPEND) begin
			wr_en          = 1'b1;
			wr_addr        = count_q[AW-1:0];
			wr_data.id     = item_q.frame_seq;
			wr_data.key    = item_q.is_keyframe;
			wr_data.handle = item_q.buffer_handle;
		end else begin
			wr_en   = mv_vld_s1;
			wr_addr = mv_dst_s1;
			wr_data = rd_data;
		end
	end

	always_comb begin
		res_fin = res_q;
		res_fin.occupancy = 4'(count_q);
	end

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= DEPTH_LIMIT_RST;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESULT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			chk_vld_s1  <= 1'b0;
			mv_vld_s1   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						idx_q      <= '0;
						chk_vld_s1 <= 1'b0;
						if (in_data.op == OP_POP) begin
							state_q <= (count_q == '0) ? ST_RESULT : ST_SCAN;
						end else begin
							state_q <= need_drop ? ST_SCAN : ST_APPEND;
						end
					end
				end
				ST_SCAN: begin
					if (hit) begin
						chk_vld_s1 <= 1'b0;
						mv_vld_s1  <= 1'b0;
						idx_q      <= CW'(hit_pos) + CW'(1);
						state_q    <= ST_SHIFT;
					end else begin
						chk_vld_s1 <= (idx_q < count_q);
						if (idx_q < count_q) begin
							idx_q <= idx_q + CW'(1);
						end
					end
				end
				ST_SHIFT: begin
					if (idx_q < count_q) begin
						mv_vld_s1 <= 1'b1;
						idx_q     <= idx_q + CW'(1);
					end else begin
						mv_vld_s1 <= 1'b0;
						if (!mv_vld_s1) begin
							count_q <= count_q - CW'(1);
							state_q <= is_pop ? ST_RESULT : ST_APPEND;
						end
					end
				end
				ST_APPEND: begin
					count_q <= count_q + CW'(1);
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			item_q <= in_data;
			res_q  <= '0;
		end
		if (state_q == ST_SCAN) begin
			chk_idx_s1 <= idx_q[AW-1:0];
			if (chk_vld_s1 && chk_idx_s1 == '0) begin
				head_q <= rd_data;
			end
			if (hit) begin
				if (is_pop) begin
					res_q.pop_valid     <= 1'b1;
					res_q.out_frame_seq <= hit_desc.id;
					res_q.out_keyframe  <= hit_desc.key;
					res_q.out_handle    <= hit_desc.handle;
				end else begin
					res_q.drop_valid     <= 1'b1;
					res_q.drop_was_key   <= hit_desc.key;
					res_q.drop_frame_seq <= hit_desc.id;
					res_q.drop_handle    <= hit_desc.handle;
				end
			end
		end
		if (state_q == ST_SHIFT) begin
			mv_dst_s1 <= AW'(idx_q - CW'(1));
		end
		if (state_q == ST_RESULT && out_free) begin
			out_q <= res_fin;
		end
	end

endmodule

/* hw/rtl/kadq_checker.sv */
// ----------------------------------------------------------------------------
// Keyframe-aware drop queue checker
// Port-level checks of the queue's transfer sequencing and result fields.
// ----------------------------------------------------------------------------
module kadq_checker
	import kadq_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// Only one operation is in flight, so an input transfer closes the input side.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted twice in a row");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed or vanished");

	a_pop_drop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.pop_valid && out_data.drop_valid))
		else $error("result reports both a pop and a drop");

	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.pop_valid |-> out_data.out_frame_seq == '0 &&
			out_data.out_handle == '0 && !out_data.out_keyframe)
		else $error("pop fields set without a popped descriptor");

endmodule

bind keyframe_aware_drop_queue_core kadq_checker u_kadq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);
